// ===== rtl/core/ubd_pkg.sv =====
// Package for the UART baud divisor and line format block.
// Holds request/response structs, divider cell state and format codes.
// No dependencies.
package ubd_pkg;

    localparam int unsigned CLK_W     = 32;
    localparam int unsigned BAUD_W    = 24;
    localparam int unsigned IDIV_W    = 28;
    localparam int unsigned QFRAC_W   = 7;
    localparam int unsigned QUO_W     = IDIV_W + QFRAC_W;
    localparam int unsigned NUM_CELLS = QUO_W;
    localparam int unsigned REM_W     = IDIV_W;
    localparam int unsigned DIV_SHIFT = 4;
    localparam int unsigned TOP_BITS  = CLK_W - IDIV_W;

    localparam logic [CLK_W-1:0] REF_CLK_RESET = 32'd14745600;

    localparam logic [7:0] LC_FIFO_EN = 8'h10;
    localparam logic [7:0] PAR_NONE   = 8'd0;
    localparam logic [7:0] PAR_EVEN   = 8'd1;
    localparam logic [7:0] PAR_ODD    = 8'd255;
    localparam logic [1:0] LC_PAR_EVEN = 2'd3;
    localparam logic [1:0] LC_PAR_ODD  = 2'd1;
    localparam logic [1:0] LC_PAR_NONE = 2'd0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FORMAT    = 2'd1;
    localparam logic [1:0] ST_ZERO_BAUD = 2'd2;

    localparam int unsigned APB_AW    = 3;
    localparam logic [0:0] REG_REF_CLK = 1'b0;

    typedef struct packed {
        logic [BAUD_W-1:0] bit_rate;
        logic [3:0]        data_bits;
        logic [7:0]        parity_mode;
        logic [1:0]        stop_bits;
    } ubd_req_t;

    typedef struct packed {
        logic [IDIV_W-1:0]  int_divisor;
        logic [QFRAC_W-1:0] frac_divisor;
        logic [7:0]         line_ctrl;
        logic [1:0]         status;
    } ubd_rsp_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] line_ctrl;
    } ubd_fmt_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
        logic [BAUD_W-1:0] baud;
        ubd_fmt_t          fmt;
    } ubd_cell_t;

endpackage

// ===== rtl/core/ubd_line_fmt.sv =====
// Line format encoder: checks bit rate, data, parity and stop fields of a request.
// Produces the line-control word and status. Depends on ubd_pkg.
module ubd_line_fmt (
    input  ubd_pkg::ubd_req_t req,
    output ubd_pkg::ubd_fmt_t fmt
);
    import ubd_pkg::*;

    logic       bad;
    logic [1:0] par_code;
    logic [1:0] len_code;

    always_comb begin
        bad      = 1'b0;
        par_code = LC_PAR_NONE;
        len_code = 2'(req.data_bits - 4'd5);
        if (req.data_bits < 4'd5 || req.data_bits > 4'd8) begin
            bad = 1'b1;
        end
        case (req.parity_mode)
            PAR_NONE: par_code = LC_PAR_NONE;
            PAR_EVEN: par_code = LC_PAR_EVEN;
            PAR_ODD:  par_code = LC_PAR_ODD;
            default:  bad = 1'b1;
        endcase
        if (req.stop_bits != 2'd1 && req.stop_bits != 2'd2) begin
            bad = 1'b1;
        end

        if (req.bit_rate == '0) begin
            fmt.status    = ST_ZERO_BAUD;
            fmt.line_ctrl = '0;
        end else if (bad) begin
            fmt.status    = ST_FORMAT;
            fmt.line_ctrl = '0;
        end else begin
            fmt.status    = ST_OK;
            fmt.line_ctrl = LC_FIFO_EN | {1'b0, len_code, 1'b0,
                                          (req.stop_bits == 2'd2), par_code, 1'b0};
        end
    end

endmodule

// ===== rtl/core/ubd_cell.sv =====
// One restoring-division cell: retires one quotient bit per stage.
// Passes remainder, dividend, quotient and format to the next cell. Depends on ubd_pkg.
module ubd_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  ubd_pkg::ubd_cell_t  in_data,
    output logic                out_valid,
    output ubd_pkg::ubd_cell_t  out_data
);
    import ubd_pkg::*;

    logic                valid_reg;
    ubd_cell_t           data_reg;
    ubd_cell_t           data_next;
    logic [REM_W:0]      r_sh;
    logic [REM_W+1:0]    diff;
    logic                borrow;

    always_comb begin
        r_sh   = {in_data.rem, in_data.num[QUO_W-1]};
        diff   = {1'b0, r_sh} - {2'b0, in_data.baud, DIV_SHIFT'(0)};
        borrow = diff[REM_W+1];

        data_next      = in_data;
        data_next.rem  = borrow ? r_sh[REM_W-1:0] : diff[REM_W-1:0];
        data_next.num  = {in_data.num[QUO_W-2:0], 1'b0};
        data_next.quo  = {in_data.quo[QUO_W-2:0], ~borrow};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/uart_baud_divisor_and_line_format.sv =====
// Top level: APB register, format encoder, chain of divider cells, output stage.
// Depends on ubd_pkg, ubd_line_fmt, ubd_cell.
//
//   channel  | ports                        | moves
//   ---------+------------------------------+-------------------------------
//   request  | s_valid s_ready s_data       | baud rate and line format
//   response | m_valid m_ready m_data       | divisors, line control, status
//   config   | psel penable pwrite paddr .. | ref_clock_hz at byte address 0
//
// One request enters per cycle while s_ready is high; its response passes
// through 35 divider cells, one quotient bit each, and then the output register.
// Synchronous active-low reset clears all valid flags; ref_clock_hz resets
// to 14745600. When m_ready is low with a response held, the whole chain
// stalls together and s_ready drops.
module uart_baud_divisor_and_line_format (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ubd_pkg::ubd_req_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ubd_pkg::ubd_rsp_t           m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ubd_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ubd_pkg::*;

    logic [CLK_W-1:0] ref_clk_reg;
    logic             m_valid_reg;
    ubd_rsp_t         m_data_reg;
    ubd_rsp_t         m_data_next;
    logic             adv;
    ubd_fmt_t         fmt;
    logic             cell_valid [0:NUM_CELLS];
    ubd_cell_t        cell_data  [0:NUM_CELLS];
    ubd_cell_t        last;
    logic [QFRAC_W-1:0] q;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_clk_reg <= REF_CLK_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_AW-1:2] == REG_REF_CLK) begin
            ref_clk_reg <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr[APB_AW-1:2])
            REG_REF_CLK: prdata = ref_clk_reg;
            default:     prdata = '0;
        endcase
    end

    // entry
    ubd_line_fmt u_fmt (
        .req (s_data),
        .fmt (fmt)
    );

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        cell_valid[0]     = s_valid;
        cell_data[0].rem  = {{(REM_W-TOP_BITS){1'b0}}, ref_clk_reg[CLK_W-1:IDIV_W]};
        cell_data[0].num  = {ref_clk_reg[IDIV_W-1:0], {QFRAC_W{1'b0}}};
        cell_data[0].quo  = '0;
        cell_data[0].baud = s_data.bit_rate;
        cell_data[0].fmt  = fmt;
    end

    // divider chain
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        ubd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // output stage
    always_comb begin
        last = cell_data[NUM_CELLS];
        q    = last.quo[QFRAC_W-1:0];
        m_data_next.int_divisor  = last.quo[QUO_W-1:QFRAC_W];
        m_data_next.frac_divisor = {1'b0, q[QFRAC_W-1:1]} + {{(QFRAC_W-1){1'b0}}, q[0]};
        m_data_next.line_ctrl    = last.fmt.line_ctrl;
        m_data_next.status       = last.fmt.status;
        if (last.fmt.status == ST_ZERO_BAUD) begin
            m_data_next.int_divisor  = '0;
            m_data_next.frac_divisor = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= cell_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/ubd_checker.sv =====
// Port-level checks for the UART baud divisor and line format block.
// Bound to the top level; depends on ubd_pkg.
module ubd_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input ubd_pkg::ubd_rsp_t    m_data
);
    import ubd_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("response valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled response changed");

    a_zero_baud: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_ZERO_BAUD |->
            m_data.int_divisor == '0 && m_data.frac_divisor == '0 && m_data.line_ctrl == '0)
        else $error("zero baud response not cleared");

    a_format: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.line_ctrl == '0)
        else $error("line control set on bad request");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.frac_divisor <= 7'd64 && m_data.status != 2'd3
            && (m_data.status != ST_OK || m_data.line_ctrl[4]))
        else $error("response field out of range");

endmodule

bind uart_baud_divisor_and_line_format ubd_checker u_ubd_checker (.*);
